FILE: src/connection_element_parser_top_defines.svh
// assertion macros used by the parser core
`ifndef CONNECTION_ELEMENT_PARSER_TOP_DEFINES_SVH
`define CONNECTION_ELEMENT_PARSER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CEP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cep assertion failed");

// next-cycle implication, disabled in reset
`define CEP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cep assertion failed");

`endif

FILE: src/cep_pkg.sv
package cep_pkg;

  localparam int MAC_BYTES_DEF   = 6;
  localparam int IDENT_BYTES_DEF = 4;
  localparam int HEADER_BYTES    = 4;

  localparam logic [7:0] MAC_MASK_BIT   = 8'b0100_0000;
  localparam logic [7:0] IDENT_MASK_BIT = 8'b0010_0000;
  localparam logic [7:0] MIN_LEN_RESET  = 8'd4;
  localparam logic [7:0] COUNT_MAX      = 8'hFF;

  typedef enum logic [1:0] {
    CFG_ELEMENT_TYPE = 2'd0,
    CFG_MEDIUM_TYPE  = 2'd1,
    CFG_MIN_LENGTH   = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TAG_HEADER = 2'd0,
    TAG_MAC    = 2'd1,
    TAG_IDENT  = 2'd2,
    TAG_ACTION = 2'd3
  } tag_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SHORT      = 3'd1,
    ST_TYPE       = 3'd2,
    ST_LENGTH     = 3'd3,
    ST_MEDIUM     = 3'd4,
    ST_MAC        = 3'd5,
    ST_IDENT      = 3'd6,
    ST_NO_ACTIONS = 3'd7
  } status_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic [1:0] field_tag;
    logic       element_end;
    logic [2:0] status;
    logic       mac_present;
    logic       ident_present;
  } out_item_t;

  typedef struct packed {
    logic     valid;
    in_item_t item;
  } in_stage_t;

  typedef struct packed {
    logic      valid;
    out_item_t item;
  } out_stage_t;

endpackage

FILE: src/cep_in_reg.sv
module cep_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cep_pkg::in_item_t in_data,
  input  logic              advance,
  output cep_pkg::in_stage_t stage
);
  import cep_pkg::*;

  logic     valid_r, valid_nxt;
  in_item_t item_r;

  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

FILE: src/cep_core.sv
`include "connection_element_parser_top_defines.svh"

module cep_core #(
  parameter int MAC_BYTES   = cep_pkg::MAC_BYTES_DEF,
  parameter int IDENT_BYTES = cep_pkg::IDENT_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data,
  input  cep_pkg::in_stage_t  stage,
  input  logic                advance,
  output cep_pkg::out_stage_t result
);
  import cep_pkg::*;

  localparam int LW = $clog2(HEADER_BYTES + MAC_BYTES + IDENT_BYTES + 256);
  localparam logic [LW-1:0] HDR_X   = LW'(HEADER_BYTES);
  localparam logic [LW-1:0] MAC_X   = LW'(MAC_BYTES);
  localparam logic [LW-1:0] IDENT_X = LW'(IDENT_BYTES);

  logic [7:0] type_code_r, medium_code_r, min_len_r;

  logic [7:0] count_r, count_nxt;
  logic       type_r, type_nxt;
  logic [7:0] dlen_r, dlen_nxt;
  logic       medium_r, medium_nxt;
  logic [1:0] presence_r, presence_nxt;

  logic          fire;
  logic [7:0]    b;
  logic [7:0]    p;
  logic [7:0]    len;
  logic [1:0]    pres;
  logic          tm, mm;
  logic [7:0]    dl;
  logic [LW-1:0] len_x, p_x, mac_end, id_base, id_end, pay_base;
  tag_t          tag;
  status_t       status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      type_code_r   <= '0;
      medium_code_r <= '0;
      min_len_r     <= MIN_LEN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ELEMENT_TYPE: type_code_r   <= cfg_data;
        CFG_MEDIUM_TYPE:  medium_code_r <= cfg_data;
        CFG_MIN_LENGTH:   min_len_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  assign fire = stage.valid && advance;
  assign b    = stage.item.byte_value;
  assign p    = count_r;

  always_comb begin
    tm   = (p == 8'd0) ? (b == type_code_r) : type_r;
    dl   = (p == 8'd1) ? b : dlen_r;
    mm   = (p == 8'd2) ? (b == medium_code_r) : medium_r;
    pres = (p == 8'd3) ? {|(b & MAC_MASK_BIT), |(b & IDENT_MASK_BIT)} : presence_r;
    len  = (p == COUNT_MAX) ? COUNT_MAX : p + 8'd1;
  end

  always_comb begin
    len_x    = LW'(len);
    p_x      = LW'(p);
    mac_end  = HDR_X + MAC_X;
    id_base  = pres[1] ? mac_end : HDR_X;
    id_end   = id_base + IDENT_X;
    pay_base = pres[0] ? id_end : id_base;
  end

  always_comb begin
    priority if (p_x < HDR_X) begin
      tag = TAG_HEADER;
    end else if (pres[1] && p_x < mac_end) begin
      tag = TAG_MAC;
    end else if (pres[0] && p_x < id_end) begin
      tag = TAG_IDENT;
    end else begin
      tag = TAG_ACTION;
    end
  end

  always_comb begin
    priority if (len < min_len_r) begin
      status = ST_SHORT;
    end else if (!tm) begin
      status = ST_TYPE;
    end else if (len < 8'd2 || dl[7] || dl != len - 8'd2) begin
      status = ST_LENGTH;
    end else if (len < 8'd3 || !mm) begin
      status = ST_MEDIUM;
    end else if (len_x < HDR_X) begin
      status = ST_NO_ACTIONS;
    end else if (pres[1] && len_x < mac_end) begin
      status = ST_MAC;
    end else if (pres[0] && len_x < id_end) begin
      status = ST_IDENT;
    end else if (len_x <= pay_base) begin
      status = ST_NO_ACTIONS;
    end else begin
      status = ST_OK;
    end
  end

  always_comb begin
    count_nxt    = count_r;
    type_nxt     = type_r;
    dlen_nxt     = dlen_r;
    medium_nxt   = medium_r;
    presence_nxt = presence_r;
    if (fire) begin
      if (stage.item.final_byte) begin
        count_nxt    = '0;
        type_nxt     = 1'b0;
        dlen_nxt     = '0;
        medium_nxt   = 1'b0;
        presence_nxt = '0;
      end else begin
        count_nxt    = len;
        type_nxt     = tm;
        dlen_nxt     = dl;
        medium_nxt   = mm;
        presence_nxt = pres;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      type_r     <= 1'b0;
      dlen_r     <= '0;
      medium_r   <= 1'b0;
      presence_r <= '0;
    end else begin
      count_r    <= count_nxt;
      type_r     <= type_nxt;
      dlen_r     <= dlen_nxt;
      medium_r   <= medium_nxt;
      presence_r <= presence_nxt;
    end
  end

  assign result.valid              = fire;
  assign result.item.data_byte     = b;
  assign result.item.field_tag     = tag;
  assign result.item.element_end   = stage.item.final_byte;
  assign result.item.status        = stage.item.final_byte ? status : ST_OK;
  assign result.item.mac_present   = pres[1];
  assign result.item.ident_present = pres[0];

  `CEP_ASSERT_NEXT(a_clear_after_end, fire && stage.item.final_byte,
    count_r == 8'd0 && presence_r == 2'b00)
  `CEP_ASSERT_NEXT(a_count_step, fire && !stage.item.final_byte && count_r != COUNT_MAX,
    count_r == $past(count_r) + 8'd1)
  `CEP_ASSERT_NEXT(a_count_hold, !fire, $stable(count_r))
  `CEP_ASSERT_NOW(a_no_mask_early, count_r < 8'd4, presence_r == 2'b00)

endmodule

FILE: src/cep_out_reg.sv
module cep_out_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  cep_pkg::out_stage_t result,
  output logic                advance,
  output logic                out_valid,
  input  logic                out_ready,
  output cep_pkg::out_item_t  out_data
);
  import cep_pkg::*;

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  assign advance = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (result.valid) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      item_r <= result.item;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = item_r;

endmodule

FILE: src/connection_element_parser_top.sv
// Parses a connection data element one byte per transaction and tags each byte as
// header, MAC, identifier or action, giving the element status with the final byte.
// One byte is taken every clock cycle while the result port is not stalled; a byte
// passes to the result port through the input register and the result register, and
// while a result waits one more byte can be held in the input register. There is no
// clearing pass after reset. Tags are tentative until the status on the final byte.
module connection_element_parser_top #(
  parameter int MAC_BYTES   = cep_pkg::MAC_BYTES_DEF,
  parameter int IDENT_BYTES = cep_pkg::IDENT_BYTES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [7:0]         cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  cep_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output cep_pkg::out_item_t out_data
);
  import cep_pkg::*;

  in_stage_t  stage;
  out_stage_t result;
  logic       advance;

  cep_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .advance  (advance),
    .stage    (stage)
  );

  cep_core #(
    .MAC_BYTES   (MAC_BYTES),
    .IDENT_BYTES (IDENT_BYTES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .stage     (stage),
    .advance   (advance),
    .result    (result)
  );

  cep_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
